FILE: sv/pip_pkg.sv
// shared types and constants for the point-in-polygon ray crossing test
// no dependencies; imported by every other module of the block
package pip_pkg;

    localparam int COORD_BITS     = 16;
    localparam int DIFF_BITS      = COORD_BITS + 1;
    localparam int PROD_BITS      = 2 * DIFF_BITS;
    localparam int SUM_BITS       = PROD_BITS + 1;
    localparam int IN_FIELD_BITS  = 4 * COORD_BITS;
    localparam int IN_TDATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = 8;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [DIFF_BITS-1:0]  t_diff;
    typedef logic signed [PROD_BITS-1:0]  t_prod;
    typedef logic signed [SUM_BITS-1:0]   t_sum;

    // far end of the ray segment is x = -1 on the query row
    localparam t_coord RAY_END_X = t_coord'(-1);

    typedef struct packed {
        t_coord sx;
        t_coord sy;
        t_coord ex;
        t_coord ey;
    } t_edge;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic use_a;
        logic use_b;
    } t_ctl;

endpackage

FILE: sv/pip_front.sv
// input stage: polygon state (query, first and previous vertex) and edge setup
// depends on pip_pkg
module pip_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_accept,
    input  logic [pip_pkg::IN_TDATA_BITS-1:0] i_tdata,
    input  logic                         i_tlast,
    output pip_pkg::t_ctl                o_ctl,
    output pip_pkg::t_edge               o_edge_a,
    output pip_pkg::t_edge               o_edge_b,
    output pip_pkg::t_coord              o_qx,
    output pip_pkg::t_coord              o_qy
);
    import pip_pkg::*;

    t_coord point_x, point_y, vertex_x, vertex_y;
    t_coord first_x, first_y;

    t_coord r_first_x, r_first_y, r_prev_x, r_prev_y, r_query_x, r_query_y;
    logic   r_open;

    t_ctl   r_ctl, n_ctl;
    t_edge  r_edge_a, r_edge_b;
    t_coord r_qx, r_qy;

    assign point_x  = t_coord'(i_tdata[0*COORD_BITS +: COORD_BITS]);
    assign point_y  = t_coord'(i_tdata[1*COORD_BITS +: COORD_BITS]);
    assign vertex_x = t_coord'(i_tdata[2*COORD_BITS +: COORD_BITS]);
    assign vertex_y = t_coord'(i_tdata[3*COORD_BITS +: COORD_BITS]);

    // the first vertex of a polygon closes onto itself
    assign first_x = r_open ? r_first_x : vertex_x;
    assign first_y = r_open ? r_first_y : vertex_y;

    always_comb begin
        n_ctl.valid = i_accept;
        n_ctl.first = !r_open;
        n_ctl.last  = i_tlast;
        n_ctl.use_a = r_open;
        n_ctl.use_b = i_tlast;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open    <= 1'b0;
            r_first_x <= '0;
            r_first_y <= '0;
            r_prev_x  <= '0;
            r_prev_y  <= '0;
            r_query_x <= '0;
            r_query_y <= '0;
        end else if (i_accept) begin
            if (!r_open) begin
                r_query_x <= point_x;
                r_query_y <= point_y;
                r_first_x <= vertex_x;
                r_first_y <= vertex_y;
            end
            r_prev_x <= vertex_x;
            r_prev_y <= vertex_y;
            r_open   <= !i_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= n_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_edge_a <= '{sx: r_prev_x, sy: r_prev_y, ex: vertex_x, ey: vertex_y};
            r_edge_b <= '{sx: vertex_x, sy: vertex_y, ex: first_x, ey: first_y};
            r_qx     <= r_open ? r_query_x : point_x;
            r_qy     <= r_open ? r_query_y : point_y;
        end
    end

    assign o_ctl    = r_ctl;
    assign o_edge_a = r_edge_a;
    assign o_edge_b = r_edge_b;
    assign o_qx     = r_qx;
    assign o_qy     = r_qy;

endmodule

FILE: sv/pip_edge.sv
// one edge against the query ray: box test and products, then straddle sign test
// depends on pip_pkg
module pip_edge (
    input  logic            i_clk,
    input  logic            i_en,
    input  pip_pkg::t_edge  i_edge,
    input  pip_pkg::t_coord i_qx,
    input  pip_pkg::t_coord i_qy,
    output logic            o_hit
);
    import pip_pkg::*;

    t_coord ymin, ymax, xmin, xmax, ray_xmin, ray_xmax;
    logic   y_ok, x_ok;
    t_diff  dx, dy, qdy, qdx, rdx;
    t_prod  n_p0, n_p1, n_p2;
    t_prod  r_p0, r_p1, r_p2;
    logic   r_pre;
    t_sum   cross_q, cross_r;
    logic   reject;

    assign ymin     = (i_edge.sy < i_edge.ey) ? i_edge.sy : i_edge.ey;
    assign ymax     = (i_edge.sy < i_edge.ey) ? i_edge.ey : i_edge.sy;
    assign xmin     = (i_edge.sx < i_edge.ex) ? i_edge.sx : i_edge.ex;
    assign xmax     = (i_edge.sx < i_edge.ex) ? i_edge.ex : i_edge.sx;
    assign ray_xmax = (i_qx > RAY_END_X) ? i_qx : RAY_END_X;
    assign ray_xmin = (i_qx > RAY_END_X) ? RAY_END_X : i_qx;

    // strict at the lower end: drops horizontal edges and a lower vertex on the ray
    assign y_ok = (i_qy > ymin) && (i_qy <= ymax);
    assign x_ok = !(ray_xmax < xmin) && !(xmax < ray_xmin);

    // with y_ok the edge endpoints never sit strictly on one side of the ray,
    // so only the edge's own straddle test remains
    assign dx  = t_diff'(i_edge.ex) - t_diff'(i_edge.sx);
    assign dy  = t_diff'(i_edge.ey) - t_diff'(i_edge.sy);
    assign qdy = t_diff'(i_qy) - t_diff'(i_edge.sy);
    assign qdx = t_diff'(i_qx) - t_diff'(i_edge.sx);
    assign rdx = ~t_diff'(i_edge.sx);

    assign n_p0 = dx * qdy;
    assign n_p1 = dy * qdx;
    assign n_p2 = dy * rdx;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0  <= n_p0;
            r_p1  <= n_p1;
            r_p2  <= n_p2;
            r_pre <= y_ok && x_ok;
        end
    end

    assign cross_q = t_sum'(r_p0) - t_sum'(r_p1);
    assign cross_r = t_sum'(r_p0) - t_sum'(r_p2);

    assign reject = ((cross_q > 0) && (cross_r > 0)) || ((cross_q < 0) && (cross_r < 0));
    assign o_hit  = r_pre && !reject;

endmodule

FILE: sv/point_in_polygon_test.sv
// top level of the point-in-polygon ray crossing test
// depends on pip_pkg, pip_front and pip_edge
//
// Polygon vertices stream in one per transfer on the slave side; the first
// transfer of a polygon also carries the query point, and tlast marks the final
// vertex. Each vertex tests the edge from the previous vertex, and the final
// vertex also tests the closing edge back to the first one. Edges are tested
// against the segment from the query point to x = -1 on the same row, in exact
// integer arithmetic; touching counts as a crossing, horizontal edges and a lower
// endpoint on the ray row are skipped. On the final vertex one result transfer
// gives inside_res = odd crossing count. Throughput is one vertex per clock while
// no result waits on the master side; a result is offered once its last vertex
// has passed the edge setup register (loaded on the accepting edge), the product
// register and the result register. The whole pipeline holds while a result waits
// on the master side; ready is high when the output register is empty or i_m_tready is high.
module point_in_polygon_test (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // slave side: vertex transfers
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: point_x, point_y, vertex_x, vertex_y (lowest bits first)
    input  logic [pip_pkg::IN_TDATA_BITS-1:0]  i_s_tdata,
    // tlast: last_vertex
    input  logic                               i_s_tlast,
    // master side: result transfers
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata: inside_res in bit 0, zero padded
    output logic [pip_pkg::OUT_TDATA_BITS-1:0] o_m_tdata
);
    import pip_pkg::*;

    logic   en;          // whole pipeline advances
    logic   accept;
    t_ctl   s1_ctl;
    t_edge  s1_edge_a, s1_edge_b;
    t_coord s1_qx, s1_qy;
    logic   hit_a, hit_b;

    t_ctl   r_s2_ctl;
    logic   r_parity, n_parity;
    logic   r_out_valid;
    logic   r_inside;

    // output register empty or draining this cycle
    assign en         = !r_out_valid || i_m_tready;
    assign o_s_tready = en;
    assign accept     = i_s_tvalid && en;

    pip_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_accept (accept),
        .i_tdata  (i_s_tdata),
        .i_tlast  (i_s_tlast),
        .o_ctl    (s1_ctl),
        .o_edge_a (s1_edge_a),
        .o_edge_b (s1_edge_b),
        .o_qx     (s1_qx),
        .o_qy     (s1_qy)
    );

    // edge from the previous vertex
    pip_edge u_edge_a (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_edge (s1_edge_a),
        .i_qx   (s1_qx),
        .i_qy   (s1_qy),
        .o_hit  (hit_a)
    );

    // closing edge back to the first vertex
    pip_edge u_edge_b (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_edge (s1_edge_b),
        .i_qx   (s1_qx),
        .i_qy   (s1_qy),
        .o_hit  (hit_b)
    );

    // control rides alongside the product registers inside the edge units
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_ctl <= '0;
        end else if (en) begin
            r_s2_ctl <= s1_ctl;
        end
    end

    // parity restarts on the first vertex of each polygon
    assign n_parity = (r_s2_ctl.first ? 1'b0 : r_parity)
                    ^ (hit_a && r_s2_ctl.use_a)
                    ^ (hit_b && r_s2_ctl.use_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_parity    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            if (r_s2_ctl.valid) begin
                r_parity <= n_parity;
            end
            r_out_valid <= r_s2_ctl.valid && r_s2_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_s2_ctl.valid && r_s2_ctl.last) begin
            r_inside <= n_parity;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(OUT_TDATA_BITS-1){1'b0}}, r_inside};

endmodule

FILE: verif/tb.sv
// self-checking testbench for point_in_polygon_test: vertex stream driver, result monitor
// and an exact integer predictor of the ray crossing parity
// depends on pip_pkg and point_in_polygon_test
module tb;
    import pip_pkg::*;

    typedef struct {
        t_coord px;
        t_coord py;
        t_coord vx;
        t_coord vy;
        logic   last;
        logic   wait_drained;  // sender holds this vertex until every result is back
    } vertex_item_t;

    logic                      i_clk      = 1'b0;
    logic                      i_rst_n    = 1'b0;
    logic                      i_s_tvalid = 1'b0;
    logic                      o_s_tready;
    // tdata: point_x, point_y, vertex_x, vertex_y (lowest bits first)
    logic [IN_TDATA_BITS-1:0]  i_s_tdata  = '0;
    // tlast: last_vertex
    logic                      i_s_tlast  = 1'b0;
    logic                      o_m_tvalid;
    logic                      i_m_tready = 1'b0;
    // tdata: inside_res in bit 0, zero padded
    logic [OUT_TDATA_BITS-1:0] o_m_tdata;

    point_in_polygon_test dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    vertex_item_t pending_vertices[$];
    logic         expected_inside[$];
    int           mismatch_count = 0;
    int           vertices_sent  = 0;
    logic         result_hold    = 1'b0;

    // predictor state: query point, first and previous vertex, parity
    longint ray_x, ray_y;
    longint poly_first_x, poly_first_y;
    longint prev_x, prev_y;
    logic   parity    = 1'b0;
    logic   poly_open = 1'b0;

    function automatic longint lo(input longint a, input longint b);
        return (a < b) ? a : b;
    endfunction

    function automatic longint hi(input longint a, input longint b);
        return (a > b) ? a : b;
    endfunction

    // sign of (b - a) x (c - a); 17-bit differences, products fit easily in 64 bits
    function automatic int orient_sign(input longint ax, ay, bx, by, cx, cy);
        longint cp;
        cp = (bx - ax) * (cy - ay) - (cx - ax) * (by - ay);
        return (cp > 0) ? 1 : ((cp < 0) ? -1 : 0);
    endfunction

    // does edge s->e toggle the parity for the ray from (qx,qy) to (-1,qy)
    function automatic bit edge_crosses(input longint qx, qy, sx, sy, ex, ey);
        longint rx;
        rx = -1;
        // horizontal edges never count
        if (sy == ey) return 1'b0;
        // lower endpoint on the ray row is skipped so a vertex counts once
        if (qy == lo(sy, ey)) return 1'b0;
        // bounding boxes apart
        if (hi(qx, rx) < lo(sx, ex) || hi(sx, ex) < lo(qx, rx) ||
            qy < lo(sy, ey) || hi(sy, ey) < qy) return 1'b0;
        // straddle tests; a zero product (touching) still counts
        if (orient_sign(qx, qy, rx, qy, sx, sy) * orient_sign(qx, qy, rx, qy, ex, ey) > 0)
            return 1'b0;
        if (orient_sign(sx, sy, ex, ey, qx, qy) * orient_sign(sx, sy, ex, ey, rx, qy) > 0)
            return 1'b0;
        return 1'b1;
    endfunction

    // update the predictor with one accepted vertex, queue the result on the last one
    task automatic predict_vertex(input vertex_item_t v);
        if (!poly_open) begin
            ray_x        = v.px;
            ray_y        = v.py;
            poly_first_x = v.vx;
            poly_first_y = v.vy;
            parity       = 1'b0;
            poly_open    = 1'b1;
        end else begin
            parity ^= edge_crosses(ray_x, ray_y, prev_x, prev_y, v.vx, v.vy);
        end
        prev_x = v.vx;
        prev_y = v.vy;
        if (v.last) begin
            // closing edge back to the first vertex
            parity ^= edge_crosses(ray_x, ray_y, v.vx, v.vy, poly_first_x, poly_first_y);
            expected_inside.push_back(parity);
            poly_open = 1'b0;
        end
    endtask

    task automatic push_vertex(input t_coord px, py, vx, vy, input logic last,
                               input logic wait_drained);
        vertex_item_t v;
        v.px           = px;
        v.py           = py;
        v.vx           = vx;
        v.vy           = vy;
        v.last         = last;
        v.wait_drained = wait_drained;
        pending_vertices.push_back(v);
    endtask

    // mode 0: full range, 1: small window around the ray end, 2: extremes mixed in
    function automatic t_coord rand_coord(input int mode);
        if (mode == 0) return t_coord'($urandom);
        if (mode == 1) return t_coord'(int'($urandom_range(0, 40)) - 20);
        case ($urandom_range(0, 5))
            0: return t_coord'(-32768);
            1: return t_coord'(32767);
            2: return t_coord'(-1);
            3: return t_coord'(0);
            4: return t_coord'(int'($urandom_range(0, 40)) - 20);
            default: return t_coord'($urandom);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // driver: presents queued vertices, random gap after each transfer
    // ---------------------------------------------------------------
    vertex_item_t current_vertex;
    int           send_gap   = 0;
    logic         send_burst = 1'b0;
    logic         offer;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
            send_gap = 0;
        end else begin
            offer = i_s_tvalid;
            if (i_s_tvalid && o_s_tready) begin
                // transfer taken at this edge
                predict_vertex(current_vertex);
                vertices_sent++;
                offer = 1'b0;
                // switch now and then between gap-free stretches and random gaps
                if ($urandom_range(0, 40) == 0) send_burst = !send_burst;
                send_gap = send_burst ? 0 : $urandom_range(0, 6);
            end
            if (!offer) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_vertices.size() > 0 &&
                             !(pending_vertices[0].wait_drained &&
                               expected_inside.size() != 0)) begin
                    current_vertex = pending_vertices.pop_front();
                    offer = 1'b1;
                    i_s_tdata <= {current_vertex.vy, current_vertex.vx,
                                  current_vertex.py, current_vertex.px};
                    i_s_tlast <= current_vertex.last;
                end
            end
            // one nonblocking write per edge so valid never glitches
            i_s_tvalid <= offer;
        end
    end

    // ---------------------------------------------------------------
    // monitor: random ready stalls, checks each result transfer in order
    // ---------------------------------------------------------------
    int   ready_wait  = 0;
    logic ready_burst = 1'b0;
    logic want_inside;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_tready <= 1'b0;
            ready_wait = 0;
        end else begin
            if (o_m_tvalid && i_m_tready) begin
                if (expected_inside.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected result transfer: inside_res=%0b", o_m_tdata[0]);
                end else begin
                    want_inside = expected_inside.pop_front();
                    if (o_m_tdata[0] !== want_inside) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("inside_res: expected %0b, got %0b",
                                     want_inside, o_m_tdata[0]);
                    end
                end
                if ($urandom_range(0, 31) == 0) ready_burst = !ready_burst;
                ready_wait = ready_burst ? 0 : $urandom_range(0, 6);
            end else if (ready_wait > 0) begin
                ready_wait--;
            end
            i_m_tready <= !result_hold && (ready_wait == 0);
        end
    end

    // long receiver hold-off while the sender keeps going, so the pipeline backs up
    initial begin : long_hold
        wait (vertices_sent >= 300);
        @(posedge i_clk);
        result_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        result_hold <= 1'b0;
    end

    // overall time limit
    initial begin : watchdog
        #2000000;
        $display("point_in_polygon_test: mismatch");
        $finish;
    end

    // ---------------------------------------------------------------
    // stimulus and end of run
    // ---------------------------------------------------------------
    initial begin : stimulus
        int     poly_count;
        int     n_vert;
        int     mode;
        t_coord qx, qy;

        // single-vertex polygon at the coordinate extremes
        push_vertex(32767, -32768, -32768, 32767, 1'b1, 1'b0);
        // two-vertex polygon: same edge both ways cancels
        push_vertex(5, 0, 3, -4, 1'b0, 1'b0);
        push_vertex(0, 0, 3, 4, 1'b1, 1'b0);
        // triangle with a clean crossing and a lower endpoint on the ray row
        push_vertex(10, 0, 2, -5, 1'b0, 1'b0);
        push_vertex(-7, 9, 2, 5, 1'b0, 1'b0);
        push_vertex(0, 0, -20, 0, 1'b1, 1'b0);
        // edge touching the far end of the ray
        push_vertex(5, 0, -1, -3, 1'b0, 1'b0);
        push_vertex(5, 0, -1, 3, 1'b0, 1'b0);
        push_vertex(5, 0, -9, 9, 1'b1, 1'b0);
        // full-range triangle
        push_vertex(32767, 0, -32768, -32768, 1'b0, 1'b0);
        push_vertex(-1, -1, 32767, 32767, 1'b0, 1'b0);
        push_vertex(-32768, 32767, 32767, -32768, 1'b1, 1'b0);
        // horizontal edge on the ray row, vertex on the ray
        push_vertex(100, 7, 50, 7, 1'b0, 1'b0);
        push_vertex(0, 0, 60, 7, 1'b0, 1'b0);
        push_vertex(0, 0, 60, -7, 1'b0, 1'b0);
        push_vertex(0, 0, 40, 20, 1'b1, 1'b0);
        // query point at x = -1: zero-length ray
        push_vertex(-1, 0, -1, -2, 1'b0, 1'b0);
        push_vertex(-1, 0, -1, 2, 1'b0, 1'b0);
        push_vertex(-1, 0, -3, 0, 1'b1, 1'b0);
        // extreme query point, quadrilateral through the corners
        push_vertex(-32768, -32768, 32767, -32768, 1'b0, 1'b0);
        push_vertex(12345, -999, -32768, 32767, 1'b0, 1'b0);
        push_vertex(32767, 32767, 0, 0, 1'b0, 1'b0);
        push_vertex(0, 0, -32768, -32768, 1'b1, 1'b0);

        // random polygons, mostly small windows where crossings and ties happen
        poly_count = 0;
        while (pending_vertices.size() < 975) begin
            mode   = ($urandom_range(0, 9) < 6) ? 1 : (($urandom_range(0, 1) == 0) ? 0 : 2);
            n_vert = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 20)
                                                   : $urandom_range(1, 8);
            if (mode == 1) begin
                qx = t_coord'(int'($urandom_range(0, 35)) - 10);
                qy = t_coord'(int'($urandom_range(0, 40)) - 20);
            end else begin
                qx = rand_coord(mode);
                qy = rand_coord(mode);
            end
            for (int k = 0; k < n_vert; k++) begin
                // point fields on later vertices are ignored, fill them with noise
                push_vertex((k == 0) ? qx : t_coord'($urandom),
                            (k == 0) ? qy : t_coord'($urandom),
                            rand_coord(mode), rand_coord(mode),
                            (k == n_vert - 1),
                            (k == 0) && (poly_count == 30 || poly_count == 150));
            end
            poly_count++;
        end

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // all vertices sent and every result back
        @(posedge i_clk);
        while (pending_vertices.size() != 0 || i_s_tvalid || expected_inside.size() != 0)
            @(posedge i_clk);
        // pipeline is three deep; give it a few extra cycles for stray results
        repeat (20) @(posedge i_clk);

        if (mismatch_count == 0 && expected_inside.size() == 0) begin
            $display("point_in_polygon_test: match");
        end else begin
            $display("point_in_polygon_test: mismatch");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/pip_pkg.sv
sv/pip_front.sv
sv/pip_edge.sv
sv/point_in_polygon_test.sv
verif/tb.sv
